### hw/rtl/il2p_header_from_ax25_frame_unit_defines.svh
// Assertion macros shared by the IL2P header encoder RTL.
`ifndef IL2P_HEADER_FROM_AX25_FRAME_UNIT_DEFINES_SVH
`define IL2P_HEADER_FROM_AX25_FRAME_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define IL2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during rst.
`define IL2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/il2p_pkg.sv
// Package with frame kind codes, decode types and lookup functions for the IL2P header encoder.
`default_nettype none

package il2p_pkg;

  localparam logic [4:0] KIND_I8     = 5'd0;
  localparam logic [4:0] KIND_I16    = 5'd1;
  localparam logic [4:0] KIND_RR8    = 5'd2;
  localparam logic [4:0] KIND_SREJ16 = 5'd9;
  localparam logic [4:0] KIND_UI     = 5'd10;
  localparam logic [4:0] KIND_SABM   = 5'd11;
  localparam logic [4:0] KIND_SABME  = 5'd12;
  localparam logic [4:0] KIND_DISC   = 5'd13;
  localparam logic [4:0] KIND_DM     = 5'd14;
  localparam logic [4:0] KIND_UA     = 5'd15;
  localparam logic [4:0] KIND_FRMR   = 5'd16;
  localparam logic [4:0] KIND_XID    = 5'd17;
  localparam logic [4:0] KIND_TEST   = 5'd18;
  localparam logic [4:0] KIND_RAW    = 5'd19;

  localparam logic [7:0] CHAR_LOW  = 8'h20;
  localparam logic [7:0] CHAR_HIGH = 8'h5F;
  localparam logic [5:0] CHAR_BIAS = 6'h20;

  localparam logic [3:0] IPID_S_FRAME = 4'h0;
  localparam logic [3:0] IPID_U_FRAME = 4'h1;

  localparam int CALL_CHARS = 6;
  localparam int SB_W       = 6 * CALL_CHARS;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic       ok;
    logic [3:0] code;
  } pid_map_t;

  // Stage 1 result: everything decoded from one frame's fields.
  typedef struct packed {
    logic [SB_W-1:0] dest_sb;
    logic [SB_W-1:0] src_sb;
    logic            calls_ok;
    logic [3:0]      to_ssid;
    logic [3:0]      from_ssid;
    logic            rep;
    logic            is_i;
    logic            is_s;
    logic            is_ui;
    logic            is_u;
    logic            is_sabme;
    pid_map_t        pid;
    logic [3:0]      u_op;
    logic [1:0]      s_op;
    logic [2:0]      ns;
    logic [2:0]      nr;
    logic            pf;
    logic            cr;
    logic [9:0]      len;
  } dec_t;

  // Stage 2 result: header fields ready to be placed.
  typedef struct packed {
    logic            type1;
    logic [SB_W-1:0] dest_sb;
    logic [3:0]      to_ssid;
    logic [SB_W-1:0] src_sb;
    logic [3:0]      from_ssid;
    logic            ui;
    logic [3:0]      ipid;
    logic [6:0]      ctrl;
    logic [9:0]      len;
  } hdr_t;

  function automatic pid_map_t map_pid(input logic [7:0] pid);
    pid_map_t r;
    r.ok = 1'b1;
    case (pid)
      8'h01:   r.code = 4'h3;
      8'h06:   r.code = 4'h4;
      8'h07:   r.code = 4'h5;
      8'h08:   r.code = 4'h6;
      8'hCC:   r.code = 4'hB;
      8'hCD:   r.code = 4'hC;
      8'hCE:   r.code = 4'hD;
      8'hCF:   r.code = 4'hE;
      8'hF0:   r.code = 4'hF;
      default: begin
        // The AX.25 layer 3 range shares one IL2P code.
        r.code = 4'h2;
        r.ok   = (pid inside {[8'h10:8'h1F]});
      end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] u_opcode(input logic [4:0] kind);
    logic [3:0] op;
    case (kind)
      KIND_SABM: op = 4'h1;
      KIND_DISC: op = 4'h3;
      KIND_DM:   op = 4'h4;
      KIND_UI:   op = 4'h5;
      KIND_UA:   op = 4'h6;
      KIND_TEST: op = 4'h7;
      KIND_FRMR: op = 4'h8;
      KIND_XID:  op = 4'h9;
      default:   op = 4'h0;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/il2p_field_decode.sv
// Decoder that classifies the frame kind, SIXBIT-encodes both callsigns and maps the PID.
`default_nettype none

module il2p_field_decode import il2p_pkg::*; (
  input  wire logic [4:0]  frame_kind,
  input  wire logic [47:0] to_call,
  input  wire logic [3:0]  to_ssid,
  input  wire logic [47:0] from_call,
  input  wire logic [3:0]  from_ssid,
  input  wire logic        has_repeaters,
  input  wire logic [7:0]  protocol_id,
  input  wire logic [2:0]  send_seq,
  input  wire logic [2:0]  recv_seq,
  input  wire logic        poll_final,
  input  wire logic        command_response,
  input  wire logic [9:0]  payload_length,
  output dec_t             dec
);

  logic [CALL_CHARS-1:0] dest_ok;
  logic [CALL_CHARS-1:0] src_ok;
  logic [7:0]            dc;
  logic [7:0]            sc;
  logic [SB_W-1:0]       dest_sb;
  logic [SB_W-1:0]       src_sb;

  // Each character is checked and rebased on its own; character k sits in byte 5-k.
  always_comb begin
    dest_sb = '0;
    src_sb  = '0;
    dest_ok = '0;
    src_ok  = '0;
    dc      = '0;
    sc      = '0;
    for (int k = 0; k < CALL_CHARS; k++) begin
      dc = to_call[8*(CALL_CHARS-1-k) +: 8];
      sc = from_call[8*(CALL_CHARS-1-k) +: 8];
      dest_ok[k] = (dc inside {[CHAR_LOW:CHAR_HIGH]});
      src_ok[k]  = (sc inside {[CHAR_LOW:CHAR_HIGH]});
      dest_sb[6*(CALL_CHARS-1-k) +: 6] = dc[5:0] - CHAR_BIAS;
      src_sb[6*(CALL_CHARS-1-k) +: 6]  = sc[5:0] - CHAR_BIAS;
    end
  end

  assign dec.dest_sb   = dest_sb;
  assign dec.src_sb    = src_sb;
  assign dec.calls_ok  = (&dest_ok) & (&src_ok);
  assign dec.to_ssid   = to_ssid;
  assign dec.from_ssid = from_ssid;
  assign dec.rep       = has_repeaters;
  assign dec.is_i      = (frame_kind inside {[KIND_I8:KIND_I16]});
  assign dec.is_s      = (frame_kind inside {[KIND_RR8:KIND_SREJ16]});
  assign dec.is_ui     = (frame_kind == KIND_UI);
  assign dec.is_u      = !dec.is_i && !dec.is_s && !dec.is_ui && (frame_kind != KIND_RAW);
  assign dec.is_sabme  = (frame_kind == KIND_SABME);
  assign dec.pid       = map_pid(protocol_id);
  assign dec.u_op      = u_opcode(frame_kind);
  assign dec.s_op      = frame_kind[1:0] - KIND_RR8[1:0];
  assign dec.ns        = send_seq;
  assign dec.nr        = recv_seq;
  assign dec.pf        = poll_final;
  assign dec.cr        = command_response;
  assign dec.len       = payload_length;

endmodule

`default_nettype wire

### hw/rtl/il2p_header_from_ax25_frame_unit.sv
// Top level of the IL2P header encoder: a three-stage pipeline from AX.25 fields to header.
`default_nettype none
`include "il2p_header_from_ax25_frame_unit_defines.svh"

// Turns the fields of one AX.25 frame into the 104-bit IL2P header. Frames with
// repeaters, SABME, a callsign character outside 0x20..0x5F or, unless they are
// S or U frames, an unmappable PID get a Type 0 header (FEC bit, type bit 0 and
// the 10-bit count, all else zero); the rest get a translated Type 1 header.
// Each request passes three register stages (decode, field build, header
// assembly) in that order on its way to the output, and one request is taken
// every cycle while the output side keeps up. A stalled stage only holds the
// stages behind it that are full, so empty slots still fill while a header
// waits.
module il2p_header_from_ax25_frame_unit import il2p_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // to_call, to_ssid, from_call, from_ssid, has_repeaters, protocol_id,
  // send_seq, recv_seq, poll_final, command_response, payload_length, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // frame_kind
  input  wire logic [4:0]            s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // header_high, header_low
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  // header_type
  output      logic                  m_axis_tuser
);

  dec_t dec_in;
  dec_t dec1;
  hdr_t hdr2;
  hdr_t hdr2_next;
  logic v1, v2, v3;
  logic ld1, ld2, ld3;
  logic [63:0] header_high_next;
  logic [39:0] header_low_next;
  logic fec_type_ok;
  logic type0_clear;

  il2p_field_decode u_decode (
    .frame_kind       (s_axis_tuser),
    .to_call          (s_axis_tdata[47:0]),
    .to_ssid          (s_axis_tdata[51:48]),
    .from_call        (s_axis_tdata[99:52]),
    .from_ssid        (s_axis_tdata[103:100]),
    .has_repeaters    (s_axis_tdata[104]),
    .protocol_id      (s_axis_tdata[112:105]),
    .send_seq         (s_axis_tdata[115:113]),
    .recv_seq         (s_axis_tdata[118:116]),
    .poll_final       (s_axis_tdata[119]),
    .command_response (s_axis_tdata[120]),
    .payload_length   (s_axis_tdata[130:121]),
    .dec              (dec_in)
  );

  // A stage loads when it is empty or its contents move on this cycle.
  assign ld3           = !v3 || m_axis_tready;
  assign ld2           = !v2 || ld3;
  assign ld1           = !v1 || ld2;
  assign s_axis_tready = ld1;
  assign m_axis_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= s_axis_tvalid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
    end
  end

  always_comb begin
    hdr2_next.type1     = !dec1.rep && dec1.calls_ok && !dec1.is_sabme &&
                          (dec1.is_s || dec1.is_u || dec1.pid.ok);
    hdr2_next.dest_sb   = dec1.dest_sb;
    hdr2_next.to_ssid   = dec1.to_ssid;
    hdr2_next.src_sb    = dec1.src_sb;
    hdr2_next.from_ssid = dec1.from_ssid;
    hdr2_next.ui        = dec1.is_ui;
    hdr2_next.len       = dec1.len;
    if (dec1.is_s) begin
      hdr2_next.ipid = IPID_S_FRAME;
    end else if (dec1.is_u) begin
      hdr2_next.ipid = IPID_U_FRAME;
    end else begin
      hdr2_next.ipid = dec1.pid.code;
    end
    if (dec1.is_i) begin
      hdr2_next.ctrl = {dec1.pf, dec1.nr, dec1.ns};
    end else if (dec1.is_s) begin
      hdr2_next.ctrl = {dec1.pf, dec1.nr, dec1.cr, dec1.s_op};
    end else begin
      // The U opcode sits in bits 4..1, so bit 5 stays clear.
      hdr2_next.ctrl = {dec1.pf, 1'b0, dec1.u_op, dec1.cr};
    end
  end

  // Type 0 keeps only the FEC bit, the type bit and the count.
  always_comb begin
    if (hdr2.type1) begin
      header_high_next = {hdr2.dest_sb, hdr2.to_ssid, hdr2.src_sb[SB_W-1:12]};
      header_low_next  = {hdr2.src_sb[11:0], hdr2.from_ssid, hdr2.ui, hdr2.ipid,
                          hdr2.ctrl, 1'b1, 1'b1, hdr2.len};
    end else begin
      header_high_next = '0;
      header_low_next  = {28'b0, 1'b1, 1'b0, hdr2.len};
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dec1 <= dec_in;
    end
    if (ld2) begin
      hdr2 <= hdr2_next;
    end
    if (ld3) begin
      m_axis_tdata <= {header_low_next, header_high_next};
      m_axis_tuser <= hdr2.type1;
    end
  end

  assign fec_type_ok = m_axis_tdata[75] && (m_axis_tdata[74] == m_axis_tuser);
  assign type0_clear = (m_axis_tdata[63:0] == '0) && (m_axis_tdata[103:76] == '0);

  `IL2P_ASSERT_IMP(a_fec_and_type, m_axis_tvalid, fec_type_ok, "FEC or type bit wrong in header")
  `IL2P_ASSERT_IMP(a_type0_clear, m_axis_tvalid && !m_axis_tuser, type0_clear, "Type 0 has fields")
  `IL2P_ASSERT_NEXT(a_stage2_hold, v2 && !ld2, v2 && $stable(hdr2), "Stalled middle stage changed")

endmodule

`default_nettype wire
